/* rtl/tcphop_pkg.sv */
// TCP header parser package: transaction types, header offsets and option kinds.
package tcphop_pkg;

   typedef struct packed {
      logic [7:0] hdr_byte;
      logic       first_byte;
      logic [4:0] addr_len;
   } req_type;

   typedef struct packed {
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  flag_bits;
      logic [5:0]  header_bytes;
      logic [15:0] max_segment;
      logic        fast_open;
      logic        status;
   } rsp_type;

   localparam logic [5:0] POS_PORT_END = 6'd4;
   localparam logic [5:0] POS_DOFF     = 6'd12;
   localparam logic [5:0] POS_FLAGS    = 6'd13;
   localparam logic [5:0] POS_LAST_MIN = 6'd19;
   localparam logic [5:0] POS_OPT      = 6'd20;
   localparam logic [5:0] HDR_MIN      = 6'd20;
   localparam logic [5:0] POS_MAX      = 6'd60;

   localparam logic [3:0] DOFF_MIN = 4'd5;
   localparam logic [4:0] ALEN_V4  = 5'd4;
   localparam logic [4:0] ALEN_V6  = 5'd16;

   localparam logic [7:0] KIND_EOL       = 8'd0;
   localparam logic [7:0] KIND_NOP       = 8'd1;
   localparam logic [7:0] KIND_MSS       = 8'd2;
   localparam logic [7:0] KIND_ECHO      = 8'd6;
   localparam logic [7:0] KIND_ECHO_RPL  = 8'd7;
   localparam logic [7:0] KIND_TSTAMP    = 8'd8;
   localparam logic [7:0] KIND_POC       = 8'd9;
   localparam logic [7:0] KIND_FASTOPEN  = 8'd34;

   localparam logic [7:0] SKIP_ECHO   = 8'd5;
   localparam logic [7:0] SKIP_TSTAMP = 8'd9;
   localparam logic [7:0] SKIP_POC    = 8'd1;
   localparam logic [7:0] OPT_LEN_MIN = 8'd2;

   localparam int FLAG_SYN = 1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

endpackage

/* rtl/tcp_header_option_parser.sv */
// TCP header and option parser: one header byte per transaction, at most one result per header.
//
// Takes one header byte per cycle; req_ready stays high while the result register is empty or
// being drained, so a full header streams at one byte a clock. All per-byte work (port
// capture, data offset check at byte 12, flags at byte 13 and the SYN option walk from byte
// 20) is a single step of logic ahead of the state registers. A result appears on rsp_ in the
// cycle after the last header byte is taken, or after byte 12 when the offset or address
// length is bad. Bytes outside a header (before the first req_data.first_byte, or after a
// result) are consumed and produce nothing; a new first_byte abandons an unfinished header.
module tcp_header_option_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  tcphop_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tcphop_pkg::rsp_type rsp_data
);
   import tcphop_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_KIND,
      PH_LEN,
      PH_SKIP,
      PH_MSSLEN,
      PH_MSSHI,
      PH_MSSLO,
      PH_STOP
   } phase_type;

   logic [5:0]  byte_pos_ff, byte_pos_in;
   logic [5:0]  hdr_len_ff, hdr_len_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  skip_left_ff, skip_left_in;
   logic [31:0] port_pair_ff, port_pair_in;
   logic [7:0]  flags_ff, flags_in;
   logic [15:0] mss_ff, mss_in;
   logic        fastopen_ff, fastopen_in;
   logic [7:0]  mss_hi_ff, mss_hi_in;
   logic        active_ff, active_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        emit;
   logic        req_take;
   logic [7:0]  b;
   logic [6:0]  pos_next;
   logic [7:0]  skip_dec;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign b         = req_data.hdr_byte;

   always_comb begin
      byte_pos_in  = byte_pos_ff;
      hdr_len_in   = hdr_len_ff;
      phase_in     = phase_ff;
      skip_left_in = skip_left_ff;
      port_pair_in = port_pair_ff;
      flags_in     = flags_ff;
      mss_in       = mss_ff;
      fastopen_in  = fastopen_ff;
      mss_hi_in    = mss_hi_ff;
      active_in    = active_ff;
      emit         = 1'b0;
      rsp_data_in  = '0;
      skip_dec     = skip_left_ff - 8'd1;

      if (req_data.first_byte) begin
         byte_pos_in  = '0;
         hdr_len_in   = '0;
         phase_in     = PH_IDLE;
         skip_left_in = '0;
         port_pair_in = '0;
         flags_in     = '0;
         mss_in       = '0;
         fastopen_in  = 1'b0;
         mss_hi_in    = '0;
         active_in    = 1'b1;
      end

      pos_next = {1'b0, byte_pos_in} + 7'd1;

      if (active_in) begin
         if (byte_pos_in < POS_PORT_END) begin
            port_pair_in = {port_pair_in[23:0], b};
         end else if (byte_pos_in == POS_DOFF) begin
            hdr_len_in = {b[7:4], 2'b00};
            if (b[7:4] < DOFF_MIN
                || (req_data.addr_len != ALEN_V4 && req_data.addr_len != ALEN_V6)) begin
               emit        = 1'b1;
               active_in   = 1'b0;
               rsp_data_in = '{src_port: port_pair_in[31:16], dst_port: port_pair_in[15:0],
                               flag_bits: 8'd0, header_bytes: {b[7:4], 2'b00},
                               max_segment: 16'd0, fast_open: 1'b0, status: STATUS_BAD};
            end
         end else if (byte_pos_in == POS_FLAGS) begin
            flags_in = b;
            phase_in = b[FLAG_SYN] ? PH_KIND : PH_IDLE;
         end else if (byte_pos_in >= POS_OPT) begin
            case (phase_ff)
               PH_KIND: begin
                  if (pos_next < {1'b0, hdr_len_in}) begin
                     case (b)
                        KIND_EOL: phase_in = PH_STOP;
                        KIND_NOP: phase_in = PH_KIND;
                        KIND_MSS: phase_in = PH_MSSLEN;
                        KIND_ECHO, KIND_ECHO_RPL: begin
                           skip_left_in = SKIP_ECHO;
                           phase_in     = PH_SKIP;
                        end
                        KIND_TSTAMP: begin
                           skip_left_in = SKIP_TSTAMP;
                           phase_in     = PH_SKIP;
                        end
                        KIND_POC: begin
                           skip_left_in = SKIP_POC;
                           phase_in     = PH_SKIP;
                        end
                        KIND_FASTOPEN: begin
                           fastopen_in = 1'b1;
                           phase_in    = PH_LEN;
                        end
                        default: phase_in = PH_LEN;
                     endcase
                  end
               end
               PH_LEN: begin
                  if (b < OPT_LEN_MIN) begin
                     phase_in = PH_STOP;
                  end else if (b == OPT_LEN_MIN) begin
                     phase_in = PH_KIND;
                  end else begin
                     skip_left_in = b - OPT_LEN_MIN;
                     phase_in     = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  skip_left_in = skip_dec;
                  if (skip_dec == 8'd0) phase_in = PH_KIND;
               end
               PH_MSSLEN: phase_in = PH_MSSHI;
               PH_MSSHI: begin
                  mss_hi_in = b;
                  phase_in  = PH_MSSLO;
               end
               PH_MSSLO: begin
                  mss_in   = {mss_hi_ff, b};
                  phase_in = PH_KIND;
               end
               default: ;
            endcase
         end

         if (!emit) begin
            if (byte_pos_in >= POS_LAST_MIN && pos_next == {1'b0, hdr_len_in}) begin
               emit        = 1'b1;
               active_in   = 1'b0;
               rsp_data_in = '{src_port: port_pair_in[31:16], dst_port: port_pair_in[15:0],
                               flag_bits: flags_in, header_bytes: hdr_len_in,
                               max_segment: mss_in, fast_open: fastopen_in,
                               status: STATUS_OK};
            end else begin
               byte_pos_in = pos_next[5:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_pos_ff  <= '0;
         hdr_len_ff   <= '0;
         phase_ff     <= PH_IDLE;
         skip_left_ff <= '0;
         port_pair_ff <= '0;
         flags_ff     <= '0;
         mss_ff       <= '0;
         fastopen_ff  <= 1'b0;
         mss_hi_ff    <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         if (req_take) begin
            byte_pos_ff  <= byte_pos_in;
            hdr_len_ff   <= hdr_len_in;
            phase_ff     <= phase_in;
            skip_left_ff <= skip_left_in;
            port_pair_ff <= port_pair_in;
            flags_ff     <= flags_in;
            mss_ff       <= mss_in;
            fastopen_ff  <= fastopen_in;
            mss_hi_ff    <= mss_hi_in;
            active_ff    <= active_in;
         end
         if (req_take && emit) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_BAD |->
         rsp_data_ff.flag_bits == 8'd0 && rsp_data_ff.max_segment == 16'd0
         && !rsp_data_ff.fast_open)
      else $error("rejected header carries option or flag data");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status == STATUS_OK |-> rsp_data_ff.header_bytes >= HDR_MIN)
      else $error("accepted header shorter than minimum");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> byte_pos_ff < POS_MAX)
      else $error("byte position past maximum header length");

   a_walk_late: assert property (@(posedge clock) disable iff (reset)
      active_ff && phase_ff != PH_IDLE |-> byte_pos_ff > POS_FLAGS)
      else $error("option walk started before flags byte");

   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      req_take && !req_data.first_byte && !active_ff |=>
         rsp_valid_ff == ($past(rsp_valid_ff) && !$past(rsp_ready)))
      else $error("result produced with no header open");
`endif

endmodule

/* sim/tcphop_tb_pkg.sv */
// Scoreboard for the TCP header parser: byte-level header predictor and result checker.
package tcphop_tb_pkg;
   import tcphop_pkg::*;

   typedef enum logic [2:0] {
      WALK_IDLE, WALK_KIND, WALK_LEN, WALK_SKIP,
      WALK_MSS_LEN, WALK_MSS_HI, WALK_MSS_LO, WALK_STOP
   } walk_phase_type;

   class header_scoreboard;
      logic [5:0]     byte_idx;
      logic [5:0]     hdr_len;
      walk_phase_type phase;
      logic [7:0]     skip_left;
      logic [31:0]    ports;
      logic [7:0]     flags;
      logic [15:0]    mss;
      logic [7:0]     mss_hi;
      logic           fast_open;
      logic           in_header;
      rsp_type        expected_q[$];
      int             mismatches;
      int             checked;
      int             rejections;

      function new();
         start_header();
         in_header  = 1'b0;
         mismatches = 0;
         checked    = 0;
         rejections = 0;
      endfunction

      function void start_header();
         byte_idx  = '0;
         hdr_len   = '0;
         phase     = WALK_IDLE;
         skip_left = '0;
         ports     = '0;
         flags     = '0;
         mss       = '0;
         mss_hi    = '0;
         fast_open = 1'b0;
      endfunction

      function void skip_bytes(logic [7:0] n);
         if (n == 8'd0) begin
            phase = WALK_KIND;
         end else begin
            skip_left = n;
            phase     = WALK_SKIP;
         end
      endfunction

      function void walk_option(logic [7:0] b);
         bit last_byte;
         last_byte = (int'(byte_idx) + 1) >= int'(hdr_len);
         case (phase)
            WALK_KIND: begin
               // a kind in the final header byte is not acted on
               if (!last_byte) begin
                  case (b)
                     KIND_EOL:                phase = WALK_STOP;
                     KIND_NOP:                ;
                     KIND_MSS:                phase = WALK_MSS_LEN;
                     KIND_ECHO, KIND_ECHO_RPL: skip_bytes(SKIP_ECHO);
                     KIND_TSTAMP:             skip_bytes(SKIP_TSTAMP);
                     KIND_POC:                skip_bytes(SKIP_POC);
                     KIND_FASTOPEN: begin
                        fast_open = 1'b1;
                        phase     = WALK_LEN;
                     end
                     default:                 phase = WALK_LEN;
                  endcase
               end
            end
            WALK_LEN: begin
               if (b < OPT_LEN_MIN) phase = WALK_STOP;
               else skip_bytes(b - OPT_LEN_MIN);
            end
            WALK_SKIP: begin
               skip_left = skip_left - 8'd1;
               if (skip_left == 8'd0) phase = WALK_KIND;
            end
            WALK_MSS_LEN: phase = WALK_MSS_HI;
            WALK_MSS_HI: begin
               mss_hi = b;
               phase  = WALK_MSS_LO;
            end
            WALK_MSS_LO: begin
               mss   = {mss_hi, b};
               phase = WALK_KIND;
            end
            default: ;
         endcase
      endfunction

      function void emit(logic [7:0] f, logic [15:0] m, logic fo, logic st);
         rsp_type res;
         res.src_port     = ports[31:16];
         res.dst_port     = ports[15:0];
         res.flag_bits    = f;
         res.header_bytes = hdr_len;
         res.max_segment  = m;
         res.fast_open    = fo;
         res.status       = st;
         expected_q.push_back(res);
         if (st == STATUS_BAD) rejections++;
         in_header = 1'b0;
      endfunction

      function void note_request(req_type item);
         logic [3:0] offset;
         if (item.first_byte) begin
            start_header();
            in_header = 1'b1;
         end
         if (!in_header) return;
         if (byte_idx < POS_PORT_END) begin
            ports = {ports[23:0], item.hdr_byte};
         end else if (byte_idx == POS_DOFF) begin
            offset  = item.hdr_byte[7:4];
            hdr_len = {offset, 2'b00};
            if (offset < DOFF_MIN ||
                (item.addr_len != ALEN_V4 && item.addr_len != ALEN_V6)) begin
               emit(8'h00, 16'h0000, 1'b0, STATUS_BAD);
               return;
            end
         end else if (byte_idx == POS_FLAGS) begin
            flags = item.hdr_byte;
            phase = item.hdr_byte[FLAG_SYN] ? WALK_KIND : WALK_IDLE;
         end else if (byte_idx >= POS_OPT) begin
            walk_option(item.hdr_byte);
         end
         if (byte_idx >= POS_LAST_MIN && int'(byte_idx) + 1 == int'(hdr_len)) begin
            emit(flags, mss, fast_open, STATUS_OK);
            return;
         end
         byte_idx = byte_idx + 6'd1;
      endfunction

      function string show(rsp_type r);
         return $sformatf("src %h dst %h flags %h len %0d mss %h fo %b st %b",
                          r.src_port, r.dst_port, r.flag_bits, r.header_bytes,
                          r.max_segment, r.fast_open, r.status);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         string   diff;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", show(got));
            return;
         end
         want = expected_q.pop_front();
         checked++;
         diff = "";
         if (got.src_port !== want.src_port)         diff = {diff, " src_port"};
         if (got.dst_port !== want.dst_port)         diff = {diff, " dst_port"};
         if (got.flag_bits !== want.flag_bits)       diff = {diff, " flag_bits"};
         if (got.header_bytes !== want.header_bytes) diff = {diff, " header_bytes"};
         if (got.max_segment !== want.max_segment)   diff = {diff, " max_segment"};
         if (got.fast_open !== want.fast_open)       diff = {diff, " fast_open"};
         if (got.status !== want.status)             diff = {diff, " status"};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on%s: expected %s, got %s", diff, show(want), show(got));
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit passed();
         return mismatches == 0 && expected_q.size() == 0;
      endfunction
   endclass

endpackage

/* sim/testbench.sv */
// Testbench top for the TCP header parser: header stimulus, handshake idling and final verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tcphop_pkg::*;
   import tcphop_tb_pkg::*;

   localparam int PHASE_BYTES  = 610;
   localparam int DRAIN_CYCLES = 20;
   localparam int BUF_BYTES    = 64;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int         send_idle_pct = 19;
   int         rsp_idle_pct  = 71;
   int         bytes_sent    = 0;
   logic [7:0] hdr_buf [BUF_BYTES];

   header_scoreboard board = new();

   tcp_header_option_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(item);
      bytes_sent++;
   endtask

   task automatic send_run(input int count, input logic [4:0] alen, input bit fresh);
      req_type item;
      for (int i = 0; i < count; i++) begin
         item.hdr_byte   = hdr_buf[i];
         item.first_byte = fresh && (i == 0);
         item.addr_len   = (i == POS_DOFF) ? alen : 5'($urandom_range(0, 31));
         send_item(item);
      end
   endtask

   function automatic void fill_random();
      for (int i = 0; i < BUF_BYTES; i++) hdr_buf[i] = 8'($urandom);
   endfunction

   function automatic void put_byte(int at, logic [7:0] v);
      if (at < BUF_BYTES) hdr_buf[at] = v;
   endfunction

   function automatic void build_options(int hlen);
      int at;
      int len;
      int sel;
      at = POS_OPT;
      while (at < hlen) begin
         sel = $urandom_range(0, 19);
         if (sel == 0) begin
            put_byte(at, KIND_EOL);
            at += 1 + $urandom_range(0, 3);
         end else if (sel <= 3) begin
            put_byte(at, KIND_NOP);
            at += 1;
         end else if (sel <= 7) begin
            put_byte(at, KIND_MSS);
            put_byte(at + 1, ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'd4);
            at += 4;
         end else if (sel == 8) begin
            put_byte(at, $urandom_range(0, 1) ? KIND_ECHO : KIND_ECHO_RPL);
            at += 6;
         end else if (sel <= 10) begin
            put_byte(at, KIND_TSTAMP);
            at += 10;
         end else if (sel == 11) begin
            put_byte(at, KIND_POC);
            at += 2;
         end else begin
            put_byte(at, (sel <= 13) ? KIND_FASTOPEN : 8'($urandom));
            case ($urandom_range(0, 9))
               0:       len = $urandom_range(0, 1);
               1:       len = $urandom_range(2, 255);
               default: len = $urandom_range(2, 10);
            endcase
            put_byte(at + 1, 8'(len));
            at += (len < 2) ? 2 : len;
         end
      end
   endfunction

   task automatic send_directed();
      // stray bytes with no header open
      hdr_buf[0] = 8'h00;
      hdr_buf[1] = 8'hFF;
      send_run(2, ALEN_V4, 1'b0);
      // short header, dropped when the next one starts
      fill_random();
      send_run(4, ALEN_V4, 1'b1);
      for (int i = 0; i < BUF_BYTES; i++) hdr_buf[i] = 8'hFF;
      hdr_buf[POS_DOFF] = {DOFF_MIN - 4'd1, 4'hF};
      send_run(POS_DOFF + 1, ALEN_V6, 1'b1);
      for (int i = 0; i < BUF_BYTES; i++) hdr_buf[i] = 8'h00;
      hdr_buf[POS_DOFF] = {4'hF, 4'h0};
      send_run(POS_DOFF + 1, ALEN_V6 + 5'd1, 1'b1);
   endtask

   task automatic random_header();
      int         pick;
      int         hlen;
      logic [3:0] offset;
      logic [4:0] alen;
      logic [7:0] flags;
      fill_random();
      pick   = $urandom_range(0, 99);
      offset = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(5, 8))
                                          : 4'($urandom_range(9, 15));
      alen   = $urandom_range(0, 1) ? ALEN_V4 : ALEN_V6;
      if (pick < 12) begin
         if ($urandom_range(0, 1)) begin
            offset = 4'($urandom_range(0, 4));
            alen   = 5'($urandom_range(0, 31));
         end else begin
            alen = 5'($urandom_range(0, 31));
            while (alen == ALEN_V4 || alen == ALEN_V6) alen = 5'($urandom_range(0, 31));
         end
      end
      hlen            = int'(offset) * 4;
      flags           = 8'($urandom);
      flags[FLAG_SYN] = ($urandom_range(0, 9) < 8);
      build_options(hlen);
      hdr_buf[POS_DOFF]  = {offset, 4'($urandom)};
      hdr_buf[POS_FLAGS] = flags;
      if (pick < 12) send_run(POS_DOFF + 1, alen, 1'b1);
      else if (pick < 22) send_run($urandom_range(1, hlen - 1), alen, 1'b1);
      else send_run(hlen, alen, 1'b1);
      // trailing bytes: ignored after a result, or continuing a cut header
      if ($urandom_range(0, 9) == 0) begin
         fill_random();
         send_run($urandom_range(1, 6), alen, 1'b0);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      send_directed();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 19 : (ph == 1) ? 71 : 0;
         rsp_idle_pct  = (ph == 0) ? 71 : (ph == 1) ? 19 : 0;
         while (bytes_sent < (ph + 1) * PHASE_BYTES) random_header();
      end
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Streamed %0d header bytes under three idling patterns; %0d results checked,",
               bytes_sent, board.checked);
      $display("%0d of them rejected at the data offset byte, %0d mismatches.",
               board.rejections, board.mismatches);
      if (board.passed()) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/tcphop_pkg.sv
rtl/tcp_header_option_parser.sv
sim/tcphop_tb_pkg.sv
sim/testbench.sv
